[rtl/core/asre_pkg.sv]
// ----------------------------------------------------------------------------
// asre_pkg
// Shared types, codes and constants of the attack/sustain ramp envelope.
// ----------------------------------------------------------------------------
package asre_pkg;

    // phase accumulator geometry
    localparam int PHASE_BITS = 20;
    localparam int PHASE_W    = PHASE_BITS + 1;
    localparam int INC_W      = 20;
    localparam int SUM_W      = ((PHASE_W > INC_W) ? PHASE_W : INC_W) + 1;

    // sample and gain geometry
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int LEVEL_W    = 16;
    localparam int VALUE_W    = 17;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int OSC_SHIFT  = 4;

    // stream payload widths
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int CODE_W     = 2;

    localparam logic [GAIN_W-1:0] GAIN_FULL = '1;

    // request kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_TRIGGER = 2'd1;
    localparam logic [1:0] KIND_FORCE   = 2'd2;

    // external stage codes
    localparam logic [CODE_W-1:0] CODE_ATTACK  = 2'd0;
    localparam logic [CODE_W-1:0] CODE_SUSTAIN = 2'd1;
    localparam logic [CODE_W-1:0] CODE_DEAD    = 2'd2;

    typedef enum logic [2:0] {
        ST_ATTACK  = 3'b001,
        ST_SUSTAIN = 3'b010,
        ST_DEAD    = 3'b100
    } stage_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [LEVEL_W-1:0] level;
        logic [CODE_W-1:0]  new_stage;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] envelope_value;
        logic [CODE_W-1:0]         stage_now;
    } result_t;

    // stage to external code
    function automatic logic [CODE_W-1:0] stage_code(input stage_t st);
        logic [CODE_W-1:0] code;
        unique case (st)
            ST_ATTACK:  code = CODE_ATTACK;
            ST_SUSTAIN: code = CODE_SUSTAIN;
            default:    code = CODE_DEAD;
        endcase
        return code;
    endfunction

    // external code to stage, unused code reads as dead
    function automatic stage_t code_stage(input logic [CODE_W-1:0] code);
        stage_t st;
        unique case (code)
            CODE_ATTACK:  st = ST_ATTACK;
            CODE_SUSTAIN: st = ST_SUSTAIN;
            default:      st = ST_DEAD;
        endcase
        return st;
    endfunction

endpackage

[rtl/core/asre_input_stage.sv]
// ----------------------------------------------------------------------------
// asre_input_stage
// Input register of the envelope: captures one request from the slave side.
// ----------------------------------------------------------------------------
module asre_input_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [asre_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [asre_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output asre_pkg::item_t                item
);
    import asre_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // room when empty or when the held request moves on this cycle
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.kind      <= s_tuser;
            item_reg.level     <= s_tdata[LEVEL_W-1:0];
            item_reg.new_stage <= s_tdata[LEVEL_W +: CODE_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[rtl/core/asre_engine.sv]
// ----------------------------------------------------------------------------
// asre_engine
// Envelope state and single-pass update: stage, phase, gain, step, level.
// ----------------------------------------------------------------------------
module asre_engine (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [asre_pkg::INC_W-1:0] cfg_data,
    input  logic                       fire,
    input  asre_pkg::item_t            item,
    output asre_pkg::result_t          result
);
    import asre_pkg::*;

    logic [INC_W-1:0]    incr_reg;
    logic [PHASE_W-1:0]  phase_reg,  phase_next;
    stage_t              stage_reg,  stage_next;
    logic [GAIN_W-1:0]   gain_reg,   gain_next;
    logic [INC_W-1:0]    step_reg,   step_next;
    logic [LEVEL_W-1:0]  level_reg,  level_next;
    logic [SAMPLE_W-1:0] raw_reg,    raw_next;

    logic                adv;
    stage_t              t_stage;
    logic [GAIN_W-1:0]   t_gain;
    logic [INC_W-1:0]    t_step;
    logic [PHASE_W-1:0]  t_phase;
    logic [PHASE_W+SAMPLE_W-1:0] phase_wide;
    logic [SAMPLE_W-1:0] osc;
    logic [PROD_W-1:0]   prod;

    // saturating phase add
    function automatic logic [PHASE_W-1:0] sat_add(input logic [PHASE_W-1:0] a,
                                                   input logic [INC_W-1:0]   b);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(a) + SUM_W'(b);
        if (sum[SUM_W-1:PHASE_W] != '0) begin
            return '1;
        end
        return sum[PHASE_W-1:0];
    endfunction

    // attack gain is (65535 * level) >> 16
    function automatic logic [GAIN_W-1:0] attack_gain(input logic [LEVEL_W-1:0] lvl);
        if (lvl == '0) begin
            return '0;
        end
        return GAIN_W'(lvl - LEVEL_W'(1));
    endfunction

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            incr_reg <= '0;
        end else if (cfg_valid) begin
            incr_reg <= cfg_data;
        end
    end

    // tick path: a trigger restarts the attack, else stage advance when the phase overflows
    always_comb begin
        adv     = phase_reg[PHASE_BITS];
        t_stage = stage_reg;
        t_gain  = gain_reg;
        t_step  = step_reg;
        t_phase = phase_reg;
        if (item.kind == KIND_TRIGGER) begin
            t_stage = ST_ATTACK;
            t_gain  = attack_gain(item.level);
            t_step  = incr_reg;
            t_phase = '0;
        end else if (adv) begin
            t_phase = '0;
            t_step  = '0;
            if (stage_reg == ST_ATTACK) begin
                t_stage = ST_SUSTAIN;
                t_gain  = GAIN_FULL;
            end else begin
                t_stage = ST_DEAD;
                t_gain  = '0;
            end
        end
    end

    // oscillator sample and scaling
    always_comb begin
        phase_wide = (PHASE_W+SAMPLE_W)'(t_phase);
        unique case (t_stage)
            ST_ATTACK:  osc = phase_wide[OSC_SHIFT +: SAMPLE_W];
            ST_SUSTAIN: osc = (item.kind == KIND_TRIGGER) ? item.level : level_reg;
            default:    osc = '0;
        endcase
        prod = PROD_W'(osc) * PROD_W'(t_gain);
    end

    // next state by request kind
    always_comb begin
        stage_next = stage_reg;
        gain_next  = gain_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        level_next = level_reg;
        raw_next   = raw_reg;
        unique case (item.kind)
            KIND_FORCE: begin
                stage_next = code_stage(item.new_stage);
                phase_next = '0;
                unique case (code_stage(item.new_stage))
                    ST_ATTACK: begin
                        gain_next = attack_gain(level_reg);
                        step_next = incr_reg;
                    end
                    ST_SUSTAIN: begin
                        gain_next = GAIN_FULL;
                        step_next = '0;
                    end
                    default: begin
                        gain_next = '0;
                        step_next = '0;
                    end
                endcase
            end
            default: begin
                // tick, trigger and the unused kind all run a tick
                if (item.kind == KIND_TRIGGER) begin
                    level_next = item.level;
                end
                stage_next = t_stage;
                gain_next  = t_gain;
                step_next  = t_step;
                raw_next   = prod[PROD_W-1 -: SAMPLE_W];
                phase_next = sat_add(t_phase, t_step);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_DEAD;
            phase_reg <= '0;
            gain_reg  <= '0;
            step_reg  <= '0;
            level_reg <= '0;
            raw_reg   <= '0;
        end else if (fire) begin
            stage_reg <= stage_next;
            phase_reg <= phase_next;
            gain_reg  <= gain_next;
            step_reg  <= step_next;
            level_reg <= level_next;
            raw_reg   <= raw_next;
        end
    end

    // result: raw output minus level plus one
    assign result.envelope_value = VALUE_W'({1'b0, raw_next}) - VALUE_W'({1'b0, level_next})
                                 + VALUE_W'(1);
    assign result.stage_now      = stage_code(stage_next);

endmodule

[rtl/core/asre_output_stage.sv]
// ----------------------------------------------------------------------------
// asre_output_stage
// Result register of the envelope: holds one result for the master side.
// ----------------------------------------------------------------------------
module asre_output_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  asre_pkg::result_t              result,
    output logic                           out_space,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [asre_pkg::M_TDATA_W-1:0] m_tdata
);
    import asre_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held result leaves this cycle
    assign out_space = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_space) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    // pack value in the low bits, stage above, zero fill
    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'({result_reg.stage_now, result_reg.envelope_value});

endmodule

[rtl/core/attack_sustain_ramp_envelope.sv]
// ----------------------------------------------------------------------------
// attack_sustain_ramp_envelope
// Attack/sustain/dead ramp envelope, one result for every request.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  s_       | in        | s_tvalid/s_tready  | tuser: kind; tdata: level, new_stage
//  m_       | out       | m_tvalid/m_tready  | tdata: envelope_value, stage_now
//  cfg_     | in        | cfg_valid/cfg_ready| cfg_data: attack_increment
//
//  one request per cycle sustained while m_tready stays high; a taken request passes the
//  input register, then the result register, which loads once it has room; the 16x16
//  gain multiply sits between them
//  reset (aresetn low, synchronous) empties both registers, stage dead
//  a stalled result keeps the block taking one more request in its input register
module attack_sustain_ramp_envelope (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [asre_pkg::S_TDATA_W-1:0] s_tdata,   // level[15:0], new_stage[17:16]
    input  logic [asre_pkg::S_TUSER_W-1:0] s_tuser,   // kind[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [asre_pkg::M_TDATA_W-1:0] m_tdata,   // envelope_value[16:0], stage_now[18:17]
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [asre_pkg::INC_W-1:0]     cfg_data
);
    import asre_pkg::*;

    logic    item_valid;
    item_t   item;
    result_t result;
    logic    out_space;
    logic    fire;

    // request moves into the engine when the result register has room
    assign fire = item_valid && out_space;

    asre_input_stage u_input (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    asre_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    asre_output_stage u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .result    (result),
        .out_space (out_space),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/core/asre_checker.sv]
// ----------------------------------------------------------------------------
// asre_checker
// Port-level checks of the envelope, bound to the top level.
// ----------------------------------------------------------------------------
module asre_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [asre_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [asre_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [asre_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [asre_pkg::INC_W-1:0]     cfg_data
);
    import asre_pkg::*;

    // a stalled result holds its data
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stage code is always one of the three stages
    a_stage_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[VALUE_W +: CODE_W] != 2'd3)
        else $error("unused stage code on output");

    // fill bits above the result fields stay zero
    a_fill_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:VALUE_W+CODE_W] == '0)
        else $error("nonzero fill bits on output");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind attack_sustain_ramp_envelope asre_checker u_asre_checker (.*);
